@@ hdl/weighted_sum_tree_sampler_unit_defines.svh @@
// Assertion macros for the weighted sum tree sampler unit.
`ifndef WEIGHTED_SUM_TREE_SAMPLER_UNIT_DEFINES_SVH
`define WEIGHTED_SUM_TREE_SAMPLER_UNIT_DEFINES_SVH

// Asserts that a condition implies a consequence in the same cycle.
`define WSTS_ASSERT_IMP(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error(msg);

// Asserts that a condition implies a consequence in the next cycle.
`define WSTS_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

@@ hdl/wsts_pkg.sv @@
//------------------------------------------------------------------------------
// wsts_pkg
// Shared constants and types of the weighted sum tree sampler.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsts_pkg;

    localparam int NUM_SITES_DEF     = 1024;
    localparam int NUM_REACTIONS_DEF = 16;
    localparam int RATE_BITS_DEF     = 32;

    localparam int ACTION_W = 3;
    localparam int SITE_W   = 10;
    localparam int REACT_W  = 4;
    localparam int IN_W     = 32;
    localparam int OUT_SUM_W = 42;

    localparam logic [ACTION_W-1:0] ACT_LOAD    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SET     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_UPDATE  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REBUILD = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE  = 3'd4;

    typedef enum logic [1:0] {
        CMD_IDLE,
        CMD_ADD,
        CMD_SAMPLE
    } t_cmd;

endpackage

@@ hdl/wsts_level_cell.sv @@
//------------------------------------------------------------------------------
// wsts_level_cell
// One tree level: memory of node sums with add, rebuild and descend steps.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsts_level_cell #(
    parameter int LEVEL = 0,
    parameter int SUM_W = 42,
    parameter int NW    = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clr,
    input  logic [NW-1:0]       i_clr_idx,
    input  logic                i_we,
    input  logic [NW-1:0]       i_widx,
    input  logic [SUM_W-1:0]    i_wdata,
    input  logic                i_add,
    input  logic [NW-1:0]       i_aidx,
    input  logic [SUM_W-1:0]    i_delta,
    input  logic [NW-1:0]       i_ridx,
    output logic [SUM_W-1:0]    o_rdata
);

    localparam int DEPTH = 1 << LEVEL;
    localparam int IW    = (LEVEL > 0) ? LEVEL : 1;

    logic [SUM_W-1:0] r_mem [DEPTH];
    logic [SUM_W-1:0] r_rdata;
    logic [SUM_W-1:0] r_adata;
    logic [IW-1:0]    r_pend_idx;
    logic [SUM_W-1:0] r_pend_delta;
    logic             r_pend;
    logic [IW-1:0]    w_ridx;
    logic [IW-1:0]    w_aidx;
    logic [IW-1:0]    w_widx;
    logic [IW-1:0]    w_cidx;

    assign w_ridx = i_ridx[IW-1:0] & IW'(DEPTH - 1);
    assign w_aidx = i_aidx[IW-1:0] & IW'(DEPTH - 1);
    assign w_widx = i_widx[IW-1:0] & IW'(DEPTH - 1);
    assign w_cidx = i_clr_idx[IW-1:0] & IW'(DEPTH - 1);

    // The add registers the old sum with the request and writes the new sum back in the cycle after.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_ridx];
        r_adata <= r_mem[w_aidx];
        if (i_clr) begin
            r_mem[w_cidx] <= '0;
        end else if (i_we) begin
            r_mem[w_widx] <= i_wdata;
        end else if (r_pend) begin
            r_mem[r_pend_idx] <= r_adata + r_pend_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_add;
        end
        r_pend_idx   <= w_aidx;
        r_pend_delta <= i_delta;
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/weighted_sum_tree_sampler_unit.sv @@
//------------------------------------------------------------------------------
// weighted_sum_tree_sampler_unit
// Sum tree over per-site rates with update, rebuild and weighted sampling.
//------------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// s_axis   in         tvalid/tready        action, site, reaction, rate, fraction
// m_axis   out        tvalid/tready        chosen_site, total_rate, lower_sum, empty
//
// Load and unknown actions pass ST_RREAD then ST_OUT, set adds ST_LREAD, and update adds
// ST_LREAD, ST_UPD and ST_UPDW; update adds its delta into every node-sum level memory at once.
// Sample scales the fraction by the total, then takes a read and a compare step per tree level.
// Rebuild takes a read and a write step per child for each node, for its two child reads.
// After reset a clearing pass over all NUM_SITES entries runs before the first transfer.
// A result waiting for m_axis_tready holds the unit only once the next one is ready.
`timescale 1ns / 1ps
`include "weighted_sum_tree_sampler_unit_defines.svh"

module weighted_sum_tree_sampler_unit #(
    parameter int NUM_SITES     = wsts_pkg::NUM_SITES_DEF,
    parameter int NUM_REACTIONS = wsts_pkg::NUM_REACTIONS_DEF,
    parameter int RATE_BITS     = wsts_pkg::RATE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[2:0], site[12:3], reaction[16:13], rate_value[48:17],
    // random_fraction[80:49], zero fill to 88 bits.
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // chosen_site[9:0], total_rate[51:10], lower_sum[93:52], tree_empty[94],
    // zero fill to 96 bits.
    output logic [95:0]  m_axis_tdata
);

    localparam int LOGN  = $clog2(NUM_SITES);
    localparam int SW    = (LOGN > 0) ? LOGN : 1;
    localparam int SUM_W = (RATE_BITS + LOGN > 64) ? 64 : RATE_BITS + LOGN;
    localparam int RW    = $clog2(NUM_REACTIONS);
    localparam int LW    = $clog2(LOGN + 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RREAD, ST_LREAD, ST_UPD, ST_UPDW,
        ST_RB_RD, ST_RB_WR, ST_SMP_MUL, ST_SMP_RD, ST_SMP_CMP, ST_OUT
    } t_state;

    t_state r_state;

    logic [wsts_pkg::ACTION_W-1:0] w_action;
    logic [wsts_pkg::SITE_W-1:0]   w_site;
    logic [wsts_pkg::REACT_W-1:0]  w_react;
    logic [31:0]                   w_rate;
    logic [31:0]                   w_frac;

    assign w_action = s_axis_tdata[2:0];
    assign w_site   = s_axis_tdata[12:3];
    assign w_react  = s_axis_tdata[16:13];
    assign w_rate   = s_axis_tdata[48:17];
    assign w_frac   = s_axis_tdata[80:49];

    logic [wsts_pkg::ACTION_W-1:0] r_action;
    logic [SW-1:0]                 r_site;
    logic [31:0]                   r_frac;
    logic [SUM_W-1:0]              r_nv;
    logic [SUM_W-1:0]              r_delta;
    logic [SW:0]                   r_cnt;
    logic [LW-1:0]                 r_lvl;
    logic [SW-1:0]                 r_node;
    logic [SUM_W-1:0]              r_t;
    logic [SUM_W-1:0]              r_lower;
    logic [SUM_W-1:0]              r_held;
    logic [SUM_W-1:0]              r_root;
    logic [SUM_W-1:0]              r_a;
    logic [SW-1:0]                 r_chosen;
    logic [95:0]                   r_out;
    logic                          r_ovalid;
    logic                          r_rb_phase;
    logic [SW-1:0]                 r_rb_node;
    logic [LW-1:0]                 r_rb_lvl;

    logic [RATE_BITS-1:0] r_react_mem [NUM_REACTIONS];
    logic [RATE_BITS-1:0] r_react_rd;
    logic [RATE_BITS-1:0] r_leaf_mem [NUM_SITES];
    logic [RATE_BITS-1:0] r_leaf_rd;
    logic [SW-1:0]        w_leaf_ridx;
    logic                 w_leaf_we;
    logic [SW-1:0]        w_leaf_widx;
    logic [RATE_BITS-1:0] w_leaf_wdata;

    // Level memories; level LOGN is the leaf memory.
    logic [SUM_W-1:0] w_lvl_rd [LOGN];
    logic [SW-1:0]    w_lvl_ridx [LOGN];
    logic [LOGN-1:0]  w_lvl_we;
    logic [SW-1:0]    w_lvl_widx;
    logic [SUM_W-1:0] w_lvl_wdata;
    logic [LOGN-1:0]  w_lvl_add;
    logic [SW-1:0]    w_lvl_aidx [LOGN];
    logic             w_clr;

    assign w_clr = (r_state == ST_CLEAR);

    genvar g;
    generate
        for (g = 0; g < LOGN; g++) begin : g_lvl
            wsts_level_cell #(
                .LEVEL (g),
                .SUM_W (SUM_W),
                .NW    (SW)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_clr     (w_clr),
                .i_clr_idx (r_cnt[SW-1:0]),
                .i_we      (w_lvl_we[g]),
                .i_widx    (w_lvl_widx),
                .i_wdata   (w_lvl_wdata),
                .i_add     (w_lvl_add[g]),
                .i_aidx    (w_lvl_aidx[g]),
                .i_delta   (r_delta),
                .i_ridx    (w_lvl_ridx[g]),
                .o_rdata   (w_lvl_rd[g])
            );
            assign w_lvl_aidx[g] = SW'(r_site >> (LOGN - g));
            assign w_lvl_add[g]  = (r_state == ST_UPDW);
            assign w_lvl_we[g]   = (r_state == ST_RB_WR) && r_rb_phase &&
                                   (r_rb_lvl == LW'(g));
        end
    endgenerate

    logic [SUM_W-1:0] w_child;
    logic [SUM_W-1:0] w_mid;
    logic [SUM_W-1:0] w_rb_sum;
    logic [SW-1:0]    w_rb_child;
    logic [SW-1:0]    w_desc_child;

    assign w_desc_child = SW'({r_node, 1'b0});
    assign w_rb_child   = SW'({r_rb_node, r_rb_phase});

    always_comb begin
        for (int k = 0; k < LOGN; k++) begin
            w_lvl_ridx[k] = (r_state == ST_RB_RD || r_state == ST_RB_WR) ? w_rb_child
                                                                          : w_desc_child;
        end
        w_lvl_ridx[0] = '0;
    end

    always_comb begin
        w_child = '0;
        if (r_lvl == LW'(LOGN - 1)) begin
            w_child = SUM_W'(r_leaf_rd);
        end else begin
            for (int k = 0; k < LOGN; k++) begin
                if (LW'(k) == r_lvl + LW'(1)) begin
                    w_child = w_lvl_rd[k];
                end
            end
        end
    end

    assign w_mid = r_lower + w_child;

    assign w_leaf_ridx = (r_state == ST_RB_RD || r_state == ST_RB_WR) ? w_rb_child
                       : (r_state == ST_SMP_RD || r_state == ST_SMP_CMP) ? w_desc_child
                       : r_site;

    always_comb begin
        w_rb_sum = '0;
        if (r_rb_lvl == LW'(LOGN - 1)) begin
            w_rb_sum = SUM_W'(r_leaf_rd);
        end else begin
            for (int k = 0; k < LOGN; k++) begin
                if (LW'(k) == r_rb_lvl + LW'(1)) begin
                    w_rb_sum = w_lvl_rd[k];
                end
            end
        end
    end

    assign w_lvl_widx  = r_rb_node;
    assign w_lvl_wdata = r_a + w_rb_sum;

    assign w_leaf_we    = (r_state == ST_LREAD) &&
                          (r_action == wsts_pkg::ACT_SET || r_action == wsts_pkg::ACT_UPDATE);
    assign w_leaf_widx  = r_site;
    assign w_leaf_wdata = RATE_BITS'(r_nv);

    always_ff @(posedge i_clk) begin
        r_leaf_rd <= r_leaf_mem[w_leaf_ridx];
        if (w_clr) begin
            r_leaf_mem[r_cnt[SW-1:0]] <= '0;
        end else if (w_leaf_we) begin
            r_leaf_mem[w_leaf_widx] <= w_leaf_wdata;
        end
        r_react_rd <= r_react_mem[w_react[RW-1:0]];
        if (w_clr) begin
            r_react_mem[r_cnt[RW-1:0]] <= '0;
        end else if (s_axis_tvalid && s_axis_tready && w_action == wsts_pkg::ACT_LOAD &&
                     32'(w_react) < 32'(NUM_REACTIONS)) begin
            r_react_mem[w_react[RW-1:0]] <= RATE_BITS'(w_rate);
        end
    end

    logic r_react_ok;
    logic [63:0] r_prod_hi;
    logic [63:0] r_prod_lo;

    assign s_axis_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_held   <= '0;
            r_root   <= '0;
        end else begin
            r_ovalid <= (r_state == ST_OUT && (!r_ovalid || m_axis_tready)) ||
                        (r_ovalid && !m_axis_tready);
            unique case (r_state)
                ST_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (SW+1)'(NUM_SITES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_action   <= w_action;
                        r_site     <= SW'(w_site);
                        r_frac     <= w_frac;
                        r_react_ok <= 32'(w_react) < 32'(NUM_REACTIONS);
                        r_chosen   <= '0;
                        r_state    <= ST_RREAD;
                    end
                end
                ST_RREAD: begin
                    r_nv <= r_react_ok ? SUM_W'(r_react_rd) : '0;
                    priority if (r_action == wsts_pkg::ACT_REBUILD) begin
                        r_rb_lvl  <= LW'(LOGN - 1);
                        r_rb_node <= SW'((NUM_SITES >> 1) - 1);
                        r_state   <= ST_RB_RD;
                    end else if (r_action == wsts_pkg::ACT_SAMPLE) begin
                        r_prod_hi <= 64'(r_frac) * 64'(r_root >> 32);
                        r_prod_lo <= 64'(r_frac) * 64'(r_root[31:0]);
                        r_state   <= ST_SMP_MUL;
                    end else if (r_action == wsts_pkg::ACT_SET ||
                                 r_action == wsts_pkg::ACT_UPDATE) begin
                        r_state <= ST_LREAD;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_LREAD: begin
                    r_delta <= r_nv - SUM_W'(r_leaf_rd);
                    r_state <= (r_action == wsts_pkg::ACT_UPDATE) ? ST_UPD : ST_OUT;
                end
                ST_UPD: begin
                    r_root  <= r_root + r_delta;
                    r_state <= ST_UPDW;
                end
                ST_UPDW: begin
                    r_state <= ST_OUT;
                end
                ST_RB_RD: begin
                    r_state <= ST_RB_WR;
                end
                ST_RB_WR: begin
                    if (!r_rb_phase) begin
                        r_a     <= w_rb_sum;
                        r_state <= ST_RB_RD;
                    end else if (r_rb_node != '0) begin
                        r_rb_node <= r_rb_node - 1'b1;
                        r_state   <= ST_RB_RD;
                    end else if (r_rb_lvl != '0) begin
                        r_rb_lvl  <= r_rb_lvl - 1'b1;
                        r_rb_node <= SW'((32'd1 << (r_rb_lvl - LW'(1))) - 32'd1);
                        r_state   <= ST_RB_RD;
                    end else begin
                        r_root  <= w_lvl_wdata;
                        r_state <= ST_OUT;
                    end
                end
                ST_SMP_MUL: begin
                    r_t     <= SUM_W'(r_prod_hi + (r_prod_lo >> 32));
                    r_lower <= '0;
                    r_node  <= '0;
                    r_lvl   <= '0;
                    r_state <= ST_SMP_RD;
                end
                ST_SMP_RD: begin
                    r_state <= ST_SMP_CMP;
                end
                ST_SMP_CMP: begin
                    if (r_t < w_mid) begin
                        r_node <= w_desc_child;
                    end else begin
                        r_node  <= w_desc_child | SW'(1);
                        r_lower <= w_mid;
                    end
                    if (r_lvl == LW'(LOGN - 1)) begin
                        r_state <= ST_OUT;
                        r_held  <= (r_t < w_mid) ? r_lower : w_mid;
                        r_chosen <= (r_t < w_mid) ? w_desc_child : (w_desc_child | SW'(1));
                    end else begin
                        r_lvl   <= r_lvl + 1'b1;
                        r_state <= ST_SMP_RD;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_out   <= {1'b0, (r_root == '0),
                                    wsts_pkg::OUT_SUM_W'(r_held),
                                    wsts_pkg::OUT_SUM_W'(r_root),
                                    wsts_pkg::SITE_W'(r_chosen)};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Rebuild reads each child pair in two read steps: left then right.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rb_phase <= 1'b0;
        end else if (r_state == ST_RB_WR) begin
            r_rb_phase <= !r_rb_phase;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    `WSTS_ASSERT_IMP(a_no_accept_busy, s_axis_tready, r_state == ST_IDLE,
        "input accepted while busy")
    `WSTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `WSTS_ASSERT_IMP(a_empty_flag, m_axis_tvalid, m_axis_tdata[94] == (m_axis_tdata[51:10] == '0),
        "empty flag mismatches total")

endmodule
